// ===== src/lad_pkg.sv =====
package lad_pkg;

    // Q16.16 fixed point.
    localparam int                 LAD_FRAC_BITS   = 16;
    localparam logic signed [18:0] LAD_Q_ONE       = 19'sh10000;
    localparam logic signed [50:0] LAD_ROUND_HALF  = 51'sh8000;

    localparam int LAD_LEVEL_WIDTH = 32;
    localparam int LAD_HYST_WIDTH  = 17;
    localparam int LAD_TICKS_WIDTH = 16;
    localparam int LAD_DELAY_WIDTH = 16;

    // Configuration register indexes.
    localparam logic [2:0] CFG_TRIP_LEVEL        = 3'd0;
    localparam logic [2:0] CFG_HYSTERESIS        = 3'd1;
    localparam logic [2:0] CFG_DIRECTION_HIGH    = 3'd2;
    localparam logic [2:0] CFG_DELAY_TICKS       = 3'd3;
    localparam logic [2:0] CFG_AUTO_RELEASE      = 3'd4;
    localparam logic [2:0] CFG_REPORT_SUPPRESSED = 3'd5;
    localparam logic [2:0] CFG_ALARM_ENABLED     = 3'd6;
    localparam logic [2:0] CFG_ALARM_ARMED       = 3'd7;

    // Item opcodes.
    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_TICK   = 2'd1;
    localparam logic [1:0] OP_RESET  = 2'd2;

    // Reported alarm state codes.
    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_WAIT    = 3'd1;
    localparam logic [2:0] ST_FIRE    = 3'd2;
    localparam logic [2:0] ST_HOLD    = 3'd3;
    localparam logic [2:0] ST_RELEASE = 3'd4;

    typedef logic [1:0]                         opcode_t;
    typedef logic signed [LAD_LEVEL_WIDTH-1:0] level_t;
    typedef logic [LAD_HYST_WIDTH-1:0]          hyst_t;
    typedef logic [LAD_TICKS_WIDTH-1:0]         ticks_t;
    typedef logic [2:0]                         state_code_t;

    typedef enum logic [4:0] {
        PH_IDLE    = 5'b00001,
        PH_WAIT    = 5'b00010,
        PH_FIRE    = 5'b00100,
        PH_HOLD    = 5'b01000,
        PH_RELEASE = 5'b10000
    } phase_t;

    function automatic state_code_t lad_state_code(input phase_t ph);
        state_code_t code;
        case (ph)
            PH_IDLE:    code = ST_IDLE;
            PH_WAIT:    code = ST_WAIT;
            PH_FIRE:    code = ST_FIRE;
            PH_HOLD:    code = ST_HOLD;
            PH_RELEASE: code = ST_RELEASE;
            default:    code = ST_IDLE;
        endcase
        return code;
    endfunction

endpackage

// ===== src/lad_if.sv =====
interface lad_item_if;
    import lad_pkg::*;

    logic    valid;
    logic    ready;
    opcode_t opcode;
    level_t  sample_value;

    modport source (output valid, output opcode, output sample_value, input ready);
    modport sink   (input valid, input opcode, input sample_value, output ready);
endinterface

interface lad_result_if;
    import lad_pkg::*;

    logic        valid;
    logic        ready;
    state_code_t alarm_state;
    logic        alarm_active;
    logic        raise_pulse;
    logic        clear_pulse;

    modport source (output valid, output alarm_state, output alarm_active,
                    output raise_pulse, output clear_pulse, input ready);
    modport sink   (input valid, input alarm_state, input alarm_active,
                    input raise_pulse, input clear_pulse, output ready);
endinterface

// ===== src/lad_release_calc.sv =====
module lad_release_calc (
    input  lad_pkg::level_t trip_level,
    input  lad_pkg::hyst_t  hysteresis_fraction,
    input  logic            direction_high,
    output lad_pkg::level_t release_level
);
    import lad_pkg::*;

    logic signed [18:0] hyst_ext;
    logic signed [18:0] factor;
    logic signed [50:0] level_ext;
    logic signed [50:0] factor_ext;
    logic signed [50:0] product;
    logic signed [50:0] rounded;
    logic signed [34:0] scaled;

    // Factor is 1+h for a low alarm and 1-h for a high one; 1-h may go negative.
    assign hyst_ext   = signed'({2'b00, hysteresis_fraction});
    assign factor     = direction_high ? (LAD_Q_ONE - hyst_ext) : (LAD_Q_ONE + hyst_ext);
    assign level_ext  = {{19{trip_level[31]}}, trip_level};
    assign factor_ext = {{32{factor[18]}}, factor};
    assign product    = level_ext * factor_ext;
    assign rounded    = product + LAD_ROUND_HALF;
    assign scaled     = rounded[50:LAD_FRAC_BITS];

    // Saturate the 35 bit result into the signed 32 bit range.
    always_comb
    begin
        if (scaled[34:31] == 4'b0000 || scaled[34:31] == 4'b1111)
        begin
            release_level = scaled[31:0];
        end
        else if (scaled[34])
        begin
            release_level = {1'b1, {31{1'b0}}};
        end
        else
        begin
            release_level = {1'b0, {31{1'b1}}};
        end
    end
endmodule

// ===== src/level_alarm_delay_hysteresis_top.sv =====
// Level alarm with pickup delay and release hysteresis. Items on the items channel
// are sample checks (signed Q16.16), timer ticks or alarm resets; each transfer in
// produces exactly one result transfer carrying the alarm state after that item and
// raise/clear pulses. A sample that reaches the trip level starts a pickup delay
// counted in tick items; a later sample that finds the delay expired fires the alarm.
// A fired alarm then either releases itself once a sample passes level*(1+h) (low
// alarm) or level*(1-h) (high alarm), or latches until a reset item. The block takes
// one item per clock unless the result register is full and not taken, which stalls
// its input; each item passes the input register, then the result register. The
// cycle time is set by the 32 by 19 bit release-level multiply, its rounding and
// saturation and the final compare, from the configuration and input registers to the
// result register. Configuration writes on cfg_we/cfg_index/cfg_data take effect at
// the next clock edge and must be made only while no item is in flight.
module level_alarm_delay_hysteresis_top #(
    parameter int DELAY_WIDTH = lad_pkg::LAD_DELAY_WIDTH
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    lad_item_if.sink     items,
    lad_result_if.source results
);
    import lad_pkg::*;

    // Largest count the delay counter can hold; loads are saturated to it.
    localparam logic [63:0] COUNT_MAX = (64'd1 << DELAY_WIDTH) - 64'd1;

    // Configuration registers.
    level_t trip_level_reg;
    hyst_t  hysteresis_reg;
    logic   direction_high_reg;
    ticks_t delay_ticks_reg;
    logic   auto_release_reg;
    logic   report_suppressed_reg;
    logic   alarm_enabled_reg;
    logic   alarm_armed_reg;

    // Input register stage.
    logic    in_valid_reg;
    opcode_t opcode_reg;
    level_t  sample_reg;

    // Alarm state.
    phase_t                 phase_reg;
    phase_t                 phase_next;
    logic                   fired_flag_reg;
    logic                   fired_flag_next;
    logic [DELAY_WIDTH-1:0] delay_count_reg;
    logic [DELAY_WIDTH-1:0] delay_count_next;
    logic                   delay_running_reg;
    logic                   delay_running_next;

    // Result register stage.
    logic        out_valid_reg;
    state_code_t out_state_reg;
    logic        out_active_reg;
    logic        out_raise_reg;
    logic        out_clear_reg;
    logic        raise_next;
    logic        clear_next;

    logic                   advance;
    logic                   process;
    logic                   crossed;
    logic                   past_release;
    level_t                 release_level;
    logic [63:0]            ticks_ext;
    logic [DELAY_WIDTH-1:0] delay_load;

    // The result register frees up when it is empty or being taken this cycle; the
    // input register frees up when its item moves on to the result register.
    assign advance       = !out_valid_reg || results.ready;
    assign process       = in_valid_reg && advance;
    assign items.ready   = !in_valid_reg || advance;

    assign results.valid        = out_valid_reg;
    assign results.alarm_state  = out_state_reg;
    assign results.alarm_active = out_active_reg;
    assign results.raise_pulse  = out_raise_reg;
    assign results.clear_pulse  = out_clear_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trip_level_reg        <= '0;
            hysteresis_reg        <= '0;
            direction_high_reg    <= 1'b0;
            delay_ticks_reg       <= '0;
            auto_release_reg      <= 1'b1;
            report_suppressed_reg <= 1'b0;
            alarm_enabled_reg     <= 1'b0;
            alarm_armed_reg       <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TRIP_LEVEL:        trip_level_reg        <= cfg_data;
                CFG_HYSTERESIS:        hysteresis_reg        <= cfg_data[LAD_HYST_WIDTH-1:0];
                CFG_DIRECTION_HIGH:    direction_high_reg    <= cfg_data[0];
                CFG_DELAY_TICKS:       delay_ticks_reg       <= cfg_data[LAD_TICKS_WIDTH-1:0];
                CFG_AUTO_RELEASE:      auto_release_reg      <= cfg_data[0];
                CFG_REPORT_SUPPRESSED: report_suppressed_reg <= cfg_data[0];
                CFG_ALARM_ENABLED:     alarm_enabled_reg     <= cfg_data[0];
                CFG_ALARM_ARMED:       alarm_armed_reg       <= cfg_data[0];
                default:               ;
            endcase
        end
    end

    // Release threshold from the current level, hysteresis and direction.
    lad_release_calc u_release (
        .trip_level          (trip_level_reg),
        .hysteresis_fraction (hysteresis_reg),
        .direction_high      (direction_high_reg),
        .release_level       (release_level)
    );

    // A low alarm trips at or below the level, a high alarm at or above it. Release
    // needs the sample strictly past the release level.
    assign crossed      = direction_high_reg ? (sample_reg >= trip_level_reg)
                                             : (sample_reg <= trip_level_reg);
    assign past_release = direction_high_reg ? (sample_reg < release_level)
                                             : (sample_reg > release_level);

    assign ticks_ext  = {{(64 - LAD_TICKS_WIDTH){1'b0}}, delay_ticks_reg};
    assign delay_load = (ticks_ext > COUNT_MAX) ? COUNT_MAX[DELAY_WIDTH-1:0]
                                                : ticks_ext[DELAY_WIDTH-1:0];

    // Next alarm state for the item in the input register.
    always_comb
    begin
        phase_next         = phase_reg;
        fired_flag_next    = fired_flag_reg;
        delay_count_next   = delay_count_reg;
        delay_running_next = delay_running_reg;
        raise_next         = 1'b0;
        clear_next         = 1'b0;

        case (opcode_reg)
            OP_SAMPLE:
            begin
                // Samples are ignored while the alarm is disabled or disarmed.
                if (alarm_enabled_reg && alarm_armed_reg)
                begin
                    case (phase_reg)
                        PH_IDLE:
                        begin
                            if (crossed)
                            begin
                                if (delay_ticks_reg == '0)
                                begin
                                    phase_next = fired_flag_reg ? PH_RELEASE : PH_FIRE;
                                end
                                else
                                begin
                                    phase_next         = PH_WAIT;
                                    delay_count_next   = delay_load;
                                    delay_running_next = 1'b1;
                                end
                            end
                        end
                        PH_WAIT:
                        begin
                            if (delay_running_reg && delay_count_reg == '0)
                            begin
                                phase_next = fired_flag_reg ? PH_RELEASE : PH_FIRE;
                            end
                            else if (!crossed)
                            begin
                                phase_next         = PH_IDLE;
                                delay_running_next = 1'b0;
                                delay_count_next   = '0;
                            end
                        end
                        PH_FIRE:
                        begin
                            raise_next      = !report_suppressed_reg;
                            fired_flag_next = 1'b1;
                            phase_next      = auto_release_reg ? PH_RELEASE : PH_HOLD;
                        end
                        PH_HOLD:
                        begin
                            if (!fired_flag_reg)
                            begin
                                phase_next = PH_IDLE;
                            end
                        end
                        PH_RELEASE:
                        begin
                            if (past_release && fired_flag_reg)
                            begin
                                fired_flag_next = 1'b0;
                                phase_next      = PH_IDLE;
                                clear_next      = 1'b1;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
            end
            OP_TICK:
            begin
                // Ticks count the pickup delay down whatever the enable state.
                if (delay_running_reg && delay_count_reg != '0)
                begin
                    delay_count_next = delay_count_reg - 1'b1;
                end
            end
            OP_RESET:
            begin
                delay_running_next = 1'b0;
                delay_count_next   = '0;
                if (fired_flag_reg)
                begin
                    fired_flag_next = 1'b0;
                    phase_next      = PH_IDLE;
                    clear_next      = 1'b1;
                end
            end
            default:
            begin
                // The unused opcode only reports the current state.
            end
        endcase
    end

    // Control state: input valid, alarm state and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            phase_reg         <= PH_IDLE;
            fired_flag_reg    <= 1'b0;
            delay_count_reg   <= '0;
            delay_running_reg <= 1'b0;
        end
        else
        begin
            if (items.ready)
            begin
                in_valid_reg <= items.valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (process)
            begin
                phase_reg         <= phase_next;
                fired_flag_reg    <= fired_flag_next;
                delay_count_reg   <= delay_count_next;
                delay_running_reg <= delay_running_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (items.valid && items.ready)
        begin
            opcode_reg <= items.opcode;
            sample_reg <= items.sample_value;
        end
        if (process)
        begin
            out_state_reg  <= lad_state_code(phase_next);
            out_active_reg <= !(phase_next == PH_IDLE || phase_next == PH_WAIT);
            out_raise_reg  <= raise_next;
            out_clear_reg  <= clear_next;
        end
    end

    // An alarm that is held or awaiting release has always fired.
    a_release_needs_fired: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_RELEASE || phase_reg == PH_HOLD) |-> fired_flag_reg)
        else $error("alarm held or awaiting release without the fired flag");

    // The active flag agrees with the reported state code.
    a_active_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_active_reg ==
            !(out_state_reg == ST_IDLE || out_state_reg == ST_WAIT)))
        else $error("alarm_active disagrees with alarm_state");

    // A raise leaves the alarm held or awaiting release, a clear leaves it idle.
    a_raise_state: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_raise_reg) |->
            (out_state_reg == ST_HOLD || out_state_reg == ST_RELEASE) && !out_clear_reg)
        else $error("raise pulse with an unexpected state");

    a_clear_state: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_clear_reg) |-> out_state_reg == ST_IDLE)
        else $error("clear pulse without returning to idle");

    // The state only moves when an item is processed.
    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !process |=> $stable(phase_reg) && $stable(fired_flag_reg)
                     && $stable(delay_count_reg))
        else $error("alarm state changed without an item");
endmodule

// ===== sim/level_alarm_delay_hysteresis_top_tb.sv =====
module level_alarm_delay_hysteresis_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lad_pkg::*;

    // Run limits and stimulus shape. The watchdog limit allows for many times the
    // slowest correct run: every transfer waiting out the longest sender gap and the
    // longest receiver stall, plus the long receiver hold-off and the settling pauses.
    localparam int      CYCLE_LIMIT     = 200000;
    localparam int      RANDOM_PHASES   = 10;
    localparam int      ITEMS_PER_PHASE = 55;
    localparam int      PRESSURE_PHASE  = 4;
    localparam int      FROZEN_PHASE    = 6;
    localparam int      LONG_HOLD       = 150;
    localparam int      MAX_WAIT        = 10;
    localparam opcode_t OP_UNUSED       = 2'd3;
    localparam level_t  LEVEL_MIN       = 32'sh8000_0000;
    localparam level_t  LEVEL_MAX       = 32'sh7FFF_FFFF;
    localparam hyst_t   HYST_ONE        = 17'h1_0000;
    localparam hyst_t   HYST_TOP        = 17'h1_FFFF;
    localparam longint  COUNT_MAX       = (longint'(1) <<< LAD_DELAY_WIDTH) - 1;

    // One result as the block reports it.
    typedef struct packed {
        state_code_t alarm_state;
        logic        alarm_active;
        logic        raise_pulse;
        logic        clear_pulse;
    } outcome_t;

    // One row of the opening sequence: either a register write or an item. Items
    // with a typed outcome are checked against that value; the rest against the
    // alarm model below.
    typedef struct {
        logic        is_write;
        logic [2:0]  reg_index;
        logic [31:0] reg_data;
        opcode_t     opcode;
        level_t      sample;
        logic        typed;
        outcome_t    want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    lad_item_if   item_ch();
    lad_result_if result_ch();

    level_alarm_delay_hysteresis_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .items     (item_ch),
        .results   (result_ch)
    );

    always #5 clk = ~clk;

    // Copy of the register file as last written, and of the alarm state. Both start
    // at their reset values.
    level_t                     trip_lvl = '0;
    hyst_t                      hyst_frac = '0;
    logic                       high_side = 1'b0;
    ticks_t                     pickup_ticks = '0;
    logic                       auto_rel = 1'b1;
    logic                       quiet = 1'b0;
    logic                       enabled = 1'b0;
    logic                       armed = 1'b0;

    state_code_t                alarm_phase = ST_IDLE;
    logic                       alarm_fired = 1'b0;
    logic [LAD_DELAY_WIDTH-1:0] pickup_count = '0;
    logic                       pickup_running = 1'b0;

    // Outcomes of accepted items whose result transfer has not yet come back.
    outcome_t pending_outcomes[$];

    int failures = 0;
    int cycle_count = 0;

    // Handshake pacing, set by the stimulus process per phase. A nonzero
    // hold_request asks the result side for one long hold-off of that length.
    bit sender_idle = 1'b0;
    bit sink_stall = 1'b0;
    int hold_request = 0;

    // Release threshold: level times (1 + h) for a low alarm or (1 - h) for a high
    // alarm, rounded to nearest Q16.16 with ties upward, then clamped to 32 bits.
    // Hysteresis above one is used as given, so 1 - h may go negative.
    function automatic level_t release_threshold();
        longint factor;
        longint scaled;
        if (high_side)
            factor = longint'(LAD_Q_ONE) - longint'(hyst_frac);
        else
            factor = longint'(LAD_Q_ONE) + longint'(hyst_frac);
        scaled = (longint'(trip_lvl) * factor + longint'(LAD_ROUND_HALF)) >>> LAD_FRAC_BITS;
        if (scaled > longint'(LEVEL_MAX))
            scaled = longint'(LEVEL_MAX);
        else if (scaled < longint'(LEVEL_MIN))
            scaled = longint'(LEVEL_MIN);
        return level_t'(scaled);
    endfunction

    function automatic logic level_crossed(level_t v);
        return high_side ? (v >= trip_lvl) : (v <= trip_lvl);
    endfunction

    // Applies one item to the alarm state and returns the result it must produce.
    function automatic outcome_t advance_alarm(opcode_t op, level_t v);
        outcome_t res;
        logic     raise;
        logic     clr;
        logic     passed;
        raise = 1'b0;
        clr = 1'b0;
        case (op)
            OP_SAMPLE:
            begin
                // Samples only count while the alarm is both enabled and armed.
                if (enabled && armed)
                begin
                    case (alarm_phase)
                        ST_IDLE:
                        begin
                            if (level_crossed(v))
                            begin
                                if (pickup_ticks == '0)
                                    alarm_phase = alarm_fired ? ST_RELEASE : ST_FIRE;
                                else
                                begin
                                    alarm_phase = ST_WAIT;
                                    if (longint'(pickup_ticks) > COUNT_MAX)
                                        pickup_count = '1;
                                    else
                                        pickup_count = pickup_ticks;
                                    pickup_running = 1'b1;
                                end
                            end
                        end
                        ST_WAIT:
                        begin
                            // An expired delay fires whatever the sample says.
                            if (pickup_running && pickup_count == '0)
                                alarm_phase = alarm_fired ? ST_RELEASE : ST_FIRE;
                            else if (!level_crossed(v))
                            begin
                                alarm_phase = ST_IDLE;
                                pickup_running = 1'b0;
                                pickup_count = '0;
                            end
                        end
                        ST_FIRE:
                        begin
                            raise = !quiet;
                            alarm_fired = 1'b1;
                            alarm_phase = auto_rel ? ST_RELEASE : ST_HOLD;
                        end
                        ST_HOLD:
                        begin
                            if (!alarm_fired)
                                alarm_phase = ST_IDLE;
                        end
                        ST_RELEASE:
                        begin
                            if (high_side)
                                passed = v < release_threshold();
                            else
                                passed = v > release_threshold();
                            if (passed && alarm_fired)
                            begin
                                alarm_fired = 1'b0;
                                alarm_phase = ST_IDLE;
                                clr = 1'b1;
                            end
                        end
                        default:
                            alarm_phase = ST_IDLE;
                    endcase
                end
            end
            OP_TICK:
            begin
                if (pickup_running && pickup_count != '0)
                    pickup_count = pickup_count - 1'b1;
            end
            OP_RESET:
            begin
                pickup_running = 1'b0;
                pickup_count = '0;
                if (alarm_fired)
                begin
                    alarm_fired = 1'b0;
                    alarm_phase = ST_IDLE;
                    clr = 1'b1;
                end
            end
            default:
            begin
                // The unused opcode only reports the current state.
            end
        endcase
        res.alarm_state = alarm_phase;
        res.alarm_active = (alarm_phase != ST_IDLE) && (alarm_phase != ST_WAIT);
        res.raise_pulse = raise;
        res.clear_pulse = clr;
        return res;
    endfunction

    function automatic outcome_t outcome(state_code_t st, logic act, logic raise, logic clr);
        outcome_t res;
        res.alarm_state = st;
        res.alarm_active = act;
        res.raise_pulse = raise;
        res.clear_pulse = clr;
        return res;
    endfunction

    function automatic stim_row_t reg_row(logic [2:0] idx, logic [31:0] data);
        stim_row_t row;
        row = '{default: '0};
        row.is_write = 1'b1;
        row.reg_index = idx;
        row.reg_data = data;
        return row;
    endfunction

    function automatic stim_row_t item_row(opcode_t op, level_t v);
        stim_row_t row;
        row = '{default: '0};
        row.opcode = op;
        row.sample = v;
        return row;
    endfunction

    function automatic stim_row_t checked_row(opcode_t op, level_t v, outcome_t want);
        stim_row_t row;
        row = item_row(op, v);
        row.typed = 1'b1;
        row.want = want;
        return row;
    endfunction

    // Drives one register write at the next edge and updates the register copy.
    // The write enable is left high; the caller lowers it after the last write.
    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            CFG_TRIP_LEVEL:        trip_lvl = level_t'(data);
            CFG_HYSTERESIS:        hyst_frac = data[LAD_HYST_WIDTH-1:0];
            CFG_DIRECTION_HIGH:    high_side = data[0];
            CFG_DELAY_TICKS:       pickup_ticks = data[LAD_TICKS_WIDTH-1:0];
            CFG_AUTO_RELEASE:      auto_rel = data[0];
            CFG_REPORT_SUPPRESSED: quiet = data[0];
            CFG_ALARM_ENABLED:     enabled = data[0];
            CFG_ALARM_ARMED:       armed = data[0];
            default:               ;
        endcase
        @(posedge clk);
    endtask

    // Offers one item, after a random gap when sender_idle is set, and waits for its
    // transfer. Valid stays high afterwards so that back-to-back items need no extra
    // edge; it is only lowered by the next gap or by settle().
    task automatic send_item(opcode_t op, level_t v, logic typed, outcome_t want);
        int       gap;
        outcome_t predicted;
        gap = sender_idle ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.opcode <= op;
        item_ch.sample_value <= v;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        // The transfer happened at this edge; the model always advances so that its
        // state stays in step, and a typed outcome takes its place in the queue.
        predicted = advance_alarm(op, v);
        pending_outcomes.push_back(typed ? want : predicted);
    endtask

    // Stops offering items and waits until every result is back and the pipeline is
    // empty, so that registers may be written.
    task automatic settle();
        item_ch.valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Result side: checks each result transfer against the oldest outstanding
    // outcome and paces ready with random stalls and the requested long hold-off.
    initial
    begin : result_sink
        int       stall_left;
        int       hold_left;
        outcome_t got;
        outcome_t want;
        stall_left = 0;
        hold_left = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
            begin
                got = outcome(result_ch.alarm_state, result_ch.alarm_active,
                              result_ch.raise_pulse, result_ch.clear_pulse);
                if (pending_outcomes.size() == 0)
                begin
                    $display("%0t: result with nothing outstanding: state %0d active %0b raise %0b clear %0b",
                             $time, got.alarm_state, got.alarm_active, got.raise_pulse,
                             got.clear_pulse);
                    failures++;
                end
                else
                begin
                    want = pending_outcomes.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: expected state %0d active %0b raise %0b clear %0b, got state %0d active %0b raise %0b clear %0b",
                                 $time, want.alarm_state, want.alarm_active, want.raise_pulse,
                                 want.clear_pulse, got.alarm_state, got.alarm_active,
                                 got.raise_pulse, got.clear_pulse);
                        failures++;
                    end
                end
                stall_left = sink_stall ? $urandom_range(0, MAX_WAIT) : 0;
            end
            if (hold_request != 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    // Watchdog: a run that hangs ends here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("level_alarm_delay_hysteresis_top_tb NOT OK");
            $finish;
        end
    end

    initial
    begin : stimulus
        stim_row_t   opening[$];
        level_t      lvl;
        level_t      v;
        hyst_t       hyst;
        ticks_t      ticks;
        logic        dir;
        logic        arm;
        opcode_t     op;
        int unsigned pick;

        item_ch.valid = 1'b0;
        item_ch.opcode = OP_SAMPLE;
        item_ch.sample_value = '0;

        // Opening sequence. Out of reset the alarm is neither enabled nor armed, so
        // samples are frozen out while ticks and resets still act. Then a low alarm
        // at level zero fires at once and releases on the first sample above zero.
        opening.push_back(checked_row(OP_SAMPLE, LEVEL_MIN, outcome(ST_IDLE, 0, 0, 0)));
        opening.push_back(checked_row(OP_UNUSED, LEVEL_MAX, outcome(ST_IDLE, 0, 0, 0)));
        opening.push_back(checked_row(OP_TICK, '0, outcome(ST_IDLE, 0, 0, 0)));
        opening.push_back(checked_row(OP_RESET, '0, outcome(ST_IDLE, 0, 0, 0)));
        opening.push_back(reg_row(CFG_ALARM_ENABLED, 32'd1));
        opening.push_back(reg_row(CFG_ALARM_ARMED, 32'd1));
        opening.push_back(checked_row(OP_SAMPLE, LEVEL_MAX, outcome(ST_IDLE, 0, 0, 0)));
        opening.push_back(checked_row(OP_SAMPLE, LEVEL_MIN, outcome(ST_FIRE, 1, 0, 0)));
        opening.push_back(checked_row(OP_SAMPLE, '0, outcome(ST_RELEASE, 1, 1, 0)));
        opening.push_back(checked_row(OP_SAMPLE, 32'sd1, outcome(ST_IDLE, 0, 0, 1)));
        // Level 1.0 with a two tick pickup delay, latching and reports suppressed.
        // The delay first aborts on a sample back over the level, then runs out, and
        // the expired delay fires even though the sample no longer crosses.
        opening.push_back(reg_row(CFG_TRIP_LEVEL, 32'h0001_0000));
        opening.push_back(reg_row(CFG_HYSTERESIS, 32'h0000_8000));
        opening.push_back(reg_row(CFG_DELAY_TICKS, 32'd2));
        opening.push_back(reg_row(CFG_AUTO_RELEASE, 32'd0));
        opening.push_back(reg_row(CFG_REPORT_SUPPRESSED, 32'd1));
        opening.push_back(checked_row(OP_SAMPLE, 32'sh0001_0000, outcome(ST_WAIT, 0, 0, 0)));
        opening.push_back(checked_row(OP_SAMPLE, 32'sh0002_0000, outcome(ST_IDLE, 0, 0, 0)));
        opening.push_back(checked_row(OP_SAMPLE, '0, outcome(ST_WAIT, 0, 0, 0)));
        opening.push_back(checked_row(OP_TICK, '0, outcome(ST_WAIT, 0, 0, 0)));
        opening.push_back(item_row(OP_TICK, LEVEL_MAX));
        opening.push_back(item_row(OP_TICK, LEVEL_MIN));
        opening.push_back(item_row(OP_SAMPLE, LEVEL_MAX));
        opening.push_back(item_row(OP_SAMPLE, '0));
        opening.push_back(item_row(OP_SAMPLE, LEVEL_MIN));
        opening.push_back(checked_row(OP_RESET, '0, outcome(ST_IDLE, 0, 0, 1)));
        // High alarm at the most negative level with hysteresis above one, so the
        // release threshold flips sign and lands near the top of the range.
        opening.push_back(reg_row(CFG_DIRECTION_HIGH, 32'd1));
        opening.push_back(reg_row(CFG_TRIP_LEVEL, 32'h8000_0000));
        opening.push_back(reg_row(CFG_HYSTERESIS, 32'h0001_FFFF));
        opening.push_back(reg_row(CFG_DELAY_TICKS, 32'd0));
        opening.push_back(reg_row(CFG_AUTO_RELEASE, 32'd1));
        opening.push_back(reg_row(CFG_REPORT_SUPPRESSED, 32'd0));
        opening.push_back(item_row(OP_SAMPLE, LEVEL_MIN));
        opening.push_back(item_row(OP_SAMPLE, '0));
        opening.push_back(item_row(OP_SAMPLE, LEVEL_MIN));
        // Disabled, then enabled but unarmed: a crossing sample changes nothing.
        opening.push_back(reg_row(CFG_ALARM_ENABLED, 32'd0));
        opening.push_back(checked_row(OP_SAMPLE, LEVEL_MAX, outcome(ST_IDLE, 0, 0, 0)));
        opening.push_back(reg_row(CFG_ALARM_ENABLED, 32'd1));
        opening.push_back(reg_row(CFG_ALARM_ARMED, 32'd0));
        opening.push_back(checked_row(OP_SAMPLE, LEVEL_MAX, outcome(ST_IDLE, 0, 0, 0)));
        opening.push_back(checked_row(OP_TICK, LEVEL_MAX, outcome(ST_IDLE, 0, 0, 0)));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening[i])
        begin
            if (opening[i].is_write)
            begin
                settle();
                write_reg(opening[i].reg_index, opening[i].reg_data);
            end
            else
            begin
                cfg_we <= 1'b0;
                send_item(opening[i].opcode, opening[i].sample, opening[i].typed,
                          opening[i].want);
            end
        end

        // Random phases. Each one rewrites every register, a few at the extremes,
        // then runs mostly samples close to the trip level or the release threshold,
        // with enough ticks for short delays to run out.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            settle();
            case (p)
                1:       lvl = LEVEL_MAX;
                2:       lvl = LEVEL_MIN;
                default:
                begin
                    case ($urandom_range(0, 3))
                        0:       lvl = '0;
                        1:       lvl = level_t'($urandom);
                        default: lvl = level_t'($urandom_range(0, 32'h8_0000)) - 32'sh4_0000;
                    endcase
                end
            endcase
            case (p)
                1:       hyst = HYST_ONE;
                2:       hyst = HYST_TOP;
                default:
                begin
                    case ($urandom_range(0, 3))
                        0:       hyst = '0;
                        1:       hyst = HYST_ONE;
                        2:       hyst = hyst_t'($urandom_range(0, 32'h1_0000));
                        default: hyst = hyst_t'($urandom_range(0, 32'h1_FFFF));
                    endcase
                end
            endcase
            // The longest delay never runs out here but keeps the counter busy.
            ticks = (p == 3) ? '1 : ticks_t'($urandom_range(0, 4));
            dir = (p == 1) ? 1'b1 : (p == 2) ? 1'b0 : 1'($urandom_range(0, 1));
            arm = (p != FROZEN_PHASE);
            write_reg(CFG_TRIP_LEVEL, 32'(lvl));
            write_reg(CFG_HYSTERESIS, 32'(hyst));
            write_reg(CFG_DIRECTION_HIGH, 32'(dir));
            write_reg(CFG_DELAY_TICKS, 32'(ticks));
            write_reg(CFG_AUTO_RELEASE, 32'($urandom_range(0, 1)));
            write_reg(CFG_REPORT_SUPPRESSED, 32'($urandom_range(0, 1)));
            write_reg(CFG_ALARM_ENABLED, 32'd1);
            write_reg(CFG_ALARM_ARMED, 32'(arm));
            cfg_we <= 1'b0;

            // Pacing: every fourth phase runs flat out on both sides, bar the pressure hold-off.
            sender_idle = (p % 4 != 0) && (p % 4 != 2);
            sink_stall = (p % 4 != 0);
            if (p == PRESSURE_PHASE)
            begin
                // Keep offering items while the result side holds off, so the
                // pipeline fills and the block has to stall its input.
                sender_idle = 1'b0;
                hold_request = LONG_HOLD;
            end

            repeat (ITEMS_PER_PHASE)
            begin
                pick = $urandom_range(0, 99);
                v = level_t'($urandom);
                if (pick < 40)
                begin
                    op = OP_SAMPLE;
                    if ($urandom_range(0, 3) == 0)
                        v = trip_lvl + level_t'($urandom_range(0, 32'h2_0000)) - 32'sh1_0000;
                    else
                        v = trip_lvl + level_t'($urandom_range(0, 6)) - 32'sd3;
                end
                else if (pick < 55)
                begin
                    op = OP_SAMPLE;
                    v = release_threshold() + level_t'($urandom_range(0, 4)) - 32'sd2;
                end
                else if (pick < 65)
                    op = OP_SAMPLE;
                else if (pick < 90)
                    op = OP_TICK;
                else if (pick < 97)
                    op = OP_RESET;
                else
                    op = OP_UNUSED;
                send_item(op, v, 1'b0, '0);
            end
        end

        // Wait for the last results, then catch anything stray.
        settle();
        repeat (4) @(posedge clk);
        if (failures == 0)
            $display("level_alarm_delay_hysteresis_top_tb OK");
        else
            $display("level_alarm_delay_hysteresis_top_tb NOT OK");
        $finish;
    end

endmodule

// ===== sim.f =====
src/lad_pkg.sv
src/lad_if.sv
src/lad_release_calc.sv
src/level_alarm_delay_hysteresis_top.sv
sim/level_alarm_delay_hysteresis_top_tb.sv
